// File: rtl/core/glider_trajectory_euler_step_defines.svh
// ----------------------------------------------------------------------------
// glider trajectory euler step assertion macros
// concurrent check wrappers for the glider_trajectory_euler_step rtl
// ----------------------------------------------------------------------------
`ifndef GLIDER_TRAJECTORY_EULER_STEP_DEFINES_SVH
`define GLIDER_TRAJECTORY_EULER_STEP_DEFINES_SVH

`ifndef ASSERT_OFF
`define GTES_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("gtes check failed");
`define GTES_ASSERT_RST(lbl, clk, prop) \
   lbl: assert property (@(posedge clk) prop) \
      else $error("gtes reset check failed");
`else
`define GTES_ASSERT(lbl, clk, rst, prop)
`define GTES_ASSERT_RST(lbl, clk, prop)
`endif

`endif

// File: rtl/core/gtes_pkg.sv
// ----------------------------------------------------------------------------
// gtes_pkg
// shared types, constants and tables of the glider euler step block
// ----------------------------------------------------------------------------
package gtes_pkg;

   localparam int CORDIC_STEPS = 24;

   typedef enum logic {
      CMD_RESTART = 1'b0,
      CMD_STEP    = 1'b1
   } cmd_type;

   typedef enum logic [1:0] {
      SH16 = 2'd0,
      SH24 = 2'd1,
      SH30 = 2'd2,
      SH38 = 2'd3
   } shift_type;

   localparam logic signed [47:0] MAX48 = {1'b0, {47{1'b1}}};
   localparam logic signed [47:0] MIN48 = {1'b1, {47{1'b0}}};

   // angles in q30 radians
   localparam logic signed [35:0] Q30_PI      = 36'sd3373259426;
   localparam logic signed [35:0] Q30_HALF_PI = 36'sd1686629713;
   localparam logic signed [35:0] Q30_TWO_PI  = 36'sd6746518852;
   localparam logic signed [35:0] Q30_GAIN    = 36'sd652032874;
   localparam logic [37:0]        TWO_PI_MAG  = 38'd6746518852;

   typedef struct packed {
      logic              start;
      logic signed [47:0] a;
      logic signed [47:0] b;
      shift_type         sh;
   } mul_req_type;

   typedef struct packed {
      logic              done;
      logic              sat;
      logic signed [47:0] value;
   } mul_rsp_type;

   typedef struct packed {
      logic              start;
      logic signed [63:0] dividend;
      logic signed [47:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic              done;
      logic              sat;
      logic signed [47:0] value;
   } div_rsp_type;

   function automatic logic [5:0] shift_amount(shift_type sh);
      case (sh)
         SH16:    return 6'd16;
         SH24:    return 6'd24;
         SH30:    return 6'd30;
         SH38:    return 6'd38;
         default: return 6'd16;
      endcase
   endfunction

   function automatic logic signed [35:0] atan_q30(logic [4:0] idx);
      case (idx)
         5'd0:    return 36'sd843314857;
         5'd1:    return 36'sd497837830;
         5'd2:    return 36'sd263043837;
         5'd3:    return 36'sd133525159;
         5'd4:    return 36'sd67021687;
         5'd5:    return 36'sd33543516;
         5'd6:    return 36'sd16775851;
         5'd7:    return 36'sd8388437;
         5'd8:    return 36'sd4194283;
         5'd9:    return 36'sd2097149;
         5'd10:   return 36'sd1048576;
         5'd11:   return 36'sd524288;
         5'd12:   return 36'sd262144;
         5'd13:   return 36'sd131072;
         5'd14:   return 36'sd65536;
         5'd15:   return 36'sd32768;
         5'd16:   return 36'sd16384;
         5'd17:   return 36'sd8192;
         5'd18:   return 36'sd4096;
         5'd19:   return 36'sd2048;
         5'd20:   return 36'sd1024;
         5'd21:   return 36'sd512;
         5'd22:   return 36'sd256;
         5'd23:   return 36'sd128;
         5'd24:   return 36'sd64;
         5'd25:   return 36'sd32;
         5'd26:   return 36'sd16;
         5'd27:   return 36'sd8;
         5'd28:   return 36'sd4;
         5'd29:   return 36'sd2;
         5'd30:   return 36'sd1;
         default: return 36'sd0;
      endcase
   endfunction

endpackage

// File: rtl/core/gtes_mul.sv
// ----------------------------------------------------------------------------
// gtes_mul
// shared 48x48 signed multiplier, 48x16 partial product per cycle,
// rounds half away from zero, shifts right and saturates to 48 bits
// ----------------------------------------------------------------------------
module gtes_mul (
   input  logic                  clock,
   input  logic                  reset,
   input  gtes_pkg::mul_req_type mul_req,
   output gtes_pkg::mul_rsp_type mul_rsp
);
   import gtes_pkg::*;

   logic [47:0] ma_ff, mb_ff;
   logic [96:0] acc_ff;
   logic        neg_ff;
   logic        busy_ff;
   logic [1:0]  cnt_ff;
   shift_type   sh_ff;
   mul_rsp_type rsp_ff;

   logic [15:0] chunk;
   logic [63:0] part;
   logic [96:0] part_sh;
   logic [96:0] rnd;
   logic [96:0] lim;
   logic [47:0] a_mag, b_mag;

   assign a_mag = mul_req.a[47] ? 48'(-mul_req.a) : 48'(mul_req.a);
   assign b_mag = mul_req.b[47] ? 48'(-mul_req.b) : 48'(mul_req.b);

   always_comb begin
      case (cnt_ff)
         2'd0:    chunk = mb_ff[15:0];
         2'd1:    chunk = mb_ff[31:16];
         2'd2:    chunk = mb_ff[47:32];
         default: chunk = '0;
      endcase
      part    = 64'(ma_ff) * 64'(chunk);
      part_sh = 97'(part) << {cnt_ff, 4'b0000};
      rnd     = acc_ff >> shift_amount(sh_ff);
      lim     = neg_ff ? (97'(1) << 47) : 97'(MAX48);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff     <= 1'b0;
         rsp_ff.done <= 1'b0;
      end else begin
         rsp_ff.done <= busy_ff && !mul_req.start && (cnt_ff == 2'd3);
         if (mul_req.start) begin
            ma_ff   <= a_mag;
            mb_ff   <= b_mag;
            neg_ff  <= mul_req.a[47] ^ mul_req.b[47];
            sh_ff   <= mul_req.sh;
            acc_ff  <= 97'(1) << (shift_amount(mul_req.sh) - 6'd1);
            cnt_ff  <= 2'd0;
            busy_ff <= 1'b1;
         end else if (busy_ff) begin
            if (cnt_ff != 2'd3) begin
               acc_ff <= acc_ff + part_sh;
               cnt_ff <= cnt_ff + 2'd1;
            end else begin
               busy_ff <= 1'b0;
               if (rnd > lim) begin
                  rsp_ff.sat   <= 1'b1;
                  rsp_ff.value <= neg_ff ? 48'(-lim) : lim[47:0];
               end else begin
                  rsp_ff.sat   <= 1'b0;
                  rsp_ff.value <= neg_ff ? 48'(-rnd) : rnd[47:0];
               end
            end
         end
      end
   end

   assign mul_rsp = rsp_ff;

endmodule

// File: rtl/core/gtes_div.sv
// ----------------------------------------------------------------------------
// gtes_div
// radix-2 restoring divider, 64-bit dividend by nonzero 48-bit divisor,
// quotient truncated toward zero and saturated to 48 bits
// ----------------------------------------------------------------------------
module gtes_div (
   input  logic                  clock,
   input  logic                  reset,
   input  gtes_pkg::div_req_type div_req,
   output gtes_pkg::div_rsp_type div_rsp
);
   import gtes_pkg::*;

   logic [63:0] quo_ff;
   logic [47:0] rem_ff;
   logic [47:0] dsr_ff;
   logic        neg_ff;
   logic        busy_ff;
   logic [6:0]  cnt_ff;
   div_rsp_type rsp_ff;

   logic [48:0] rem_sh;
   logic [48:0] rem_sub;
   logic        take;

   assign rem_sh  = {rem_ff, quo_ff[63]};
   assign rem_sub = rem_sh - 49'(dsr_ff);
   assign take    = (rem_sh >= 49'(dsr_ff));

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff     <= 1'b0;
         rsp_ff.done <= 1'b0;
      end else begin
         rsp_ff.done <= busy_ff && !div_req.start && (cnt_ff == 7'd64);
         if (div_req.start) begin
            quo_ff  <= div_req.dividend[63] ? 64'(-div_req.dividend) : 64'(div_req.dividend);
            dsr_ff  <= div_req.divisor[47] ? 48'(-div_req.divisor) : 48'(div_req.divisor);
            neg_ff  <= div_req.dividend[63] ^ div_req.divisor[47];
            rem_ff  <= '0;
            cnt_ff  <= '0;
            busy_ff <= 1'b1;
         end else if (busy_ff) begin
            if (cnt_ff != 7'd64) begin
               rem_ff <= take ? rem_sub[47:0] : rem_sh[47:0];
               quo_ff <= {quo_ff[62:0], take};
               cnt_ff <= cnt_ff + 7'd1;
            end else begin
               busy_ff <= 1'b0;
               if (neg_ff) begin
                  if (quo_ff > (64'(1) << 47)) begin
                     rsp_ff.sat   <= 1'b1;
                     rsp_ff.value <= MIN48;
                  end else begin
                     rsp_ff.sat   <= 1'b0;
                     rsp_ff.value <= 48'(-quo_ff);
                  end
               end else begin
                  if (quo_ff > 64'(MAX48)) begin
                     rsp_ff.sat   <= 1'b1;
                     rsp_ff.value <= MAX48;
                  end else begin
                     rsp_ff.sat   <= 1'b0;
                     rsp_ff.value <= quo_ff[47:0];
                  end
               end
            end
         end
      end
   end

   assign div_rsp = rsp_ff;

endmodule

// File: rtl/core/glider_trajectory_euler_step.sv
// ----------------------------------------------------------------------------
// glider_trajectory_euler_step
// explicit euler step of a point-mass glider in the vertical plane
// ----------------------------------------------------------------------------
//  channel  direction  tdata / tuser
//  req      in         speed, angle, distance, height / command
//  rsp      out        time, speed, angle, distance, height / finished, saturated
//  csr      in         write enable, index, 48-bit data
//
//  a restart beat or a finished step goes from accept to the output state;
//  a step beat runs accept, range reduction (mod, sign, wrap, half), the
//  cordic rotations, two passes through the shared multiplier, the divider
//  (skipped at zero speed), rate, nine more multiplier passes, commit, output.
//  one beat at a time: req_tready is high only while the sequencer is idle.
//  the result waits in an output register, rsp_tready low stalls only the
//  hand-over of the next result. synchronous active-high reset.
// ----------------------------------------------------------------------------
`include "glider_trajectory_euler_step_defines.svh"

module glider_trajectory_euler_step (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // start_speed, start_angle, start_distance, start_height
   input  logic [175:0] req_tdata,
   // command
   input  logic [0:0]   req_tuser,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // sim_time, speed, path_angle, distance, height
   output logic [223:0] rsp_tdata,
   // finished, saturated
   output logic [1:0]   rsp_tuser,
   input  logic         csr_we,
   input  logic [2:0]   csr_index,
   input  logic [47:0]  csr_wdata
);
   import gtes_pkg::*;

   typedef enum logic [3:0] {
      S_IDLE, S_MOD, S_SIGN, S_WRAP, S_HALF, S_ROT, S_MUL_GO, S_MUL_WAIT,
      S_DIV, S_DIV_WAIT, S_RATE, S_COMMIT, S_OUT
   } state_type;

   typedef enum logic [3:0] {
      OP_KLV, OP_GC, OP_NA, OP_V2, OP_T1, OP_T2, OP_NV, OP_VC, OP_NX, OP_VS, OP_NH
   } op_type;

   localparam logic [2:0] REG_LIFT = 3'd0;
   localparam logic [2:0] REG_DRAG = 3'd1;
   localparam logic [2:0] REG_GRAV = 3'd2;
   localparam logic [2:0] REG_DT   = 3'd3;
   localparam logic [2:0] REG_END  = 3'd4;
   localparam logic [4:0] LAST_ROT = 5'(CORDIC_STEPS - 1);

   function automatic logic [48:0] clamp48(logic signed [48:0] v);
      if (v[48] != v[47]) return {1'b1, v[48] ? MIN48 : MAX48};
      return {1'b0, v[47:0]};
   endfunction

   function automatic logic [32:0] clamp32(logic signed [48:0] v);
      if (v[48:31] != {18{v[48]}}) return {1'b1, v[48], {31{~v[48]}}};
      return {1'b0, v[31:0]};
   endfunction

   // configuration
   logic [31:0] lift_ff, drag_ff, grav_ff, dt_ff;
   logic [47:0] end_ff;

   state_type state_ff;
   op_type    op_ff;

   logic [47:0]        time_ff;
   logic signed [47:0] speed_ff, dist_ff, height_ff;
   logic signed [31:0] angle_ff;
   logic               run_over_ff;

   logic signed [31:0] na_ff;
   logic signed [47:0] nv_ff, nx_ff, nh_ff;
   logic signed [47:0] klv_ff, gc_ff, q_ff, term_ff, v2_ff, t1_ff;
   logic               sat_ff;

   logic [2:0]         k_ff;
   logic [4:0]         i_ff;
   logic [37:0]        zmag_ff;
   logic               zneg_ff, flip_ff;
   logic signed [35:0] z_ff, x_ff, y_ff, c_ff, s_ff;

   logic [47:0]        rec_time_ff;
   logic signed [47:0] rec_speed_ff, rec_dist_ff, rec_height_ff;
   logic signed [31:0] rec_angle_ff;
   logic               fin_rec_ff;

   logic               rsp_tvalid_ff;
   logic [223:0]       rsp_tdata_ff;
   logic [1:0]         rsp_tuser_ff;

   mul_req_type mul_req;
   mul_rsp_type mul_rsp;
   div_req_type div_req;
   div_rsp_type div_rsp;

   logic               req_beat;
   logic               rsp_load;
   logic signed [47:0] in_speed, in_dist, in_height;
   logic signed [31:0] in_angle;
   logic signed [37:0] z38;
   logic [37:0]        z_abs;
   logic [37:0]        mod_step;
   logic signed [35:0] xs, ys, x_in, y_in;
   logic signed [48:0] add_na, add_t2, add_nv, add_nx, add_nh, add_rate;
   logic [32:0]        cl_na;
   logic [48:0]        cl_t2, cl_nv, cl_nx, cl_nh, cl_rate;
   logic [48:0]        nt_sum;
   logic [32:0]        dt_rnd;

   assign in_speed  = req_tdata[47:0];
   assign in_angle  = req_tdata[79:48];
   assign in_dist   = req_tdata[127:80];
   assign in_height = req_tdata[175:128];

   assign req_tready = (state_ff == S_IDLE);
   assign req_beat   = req_tvalid && req_tready;
   assign rsp_load   = (state_ff == S_OUT) && (!rsp_tvalid_ff || rsp_tready);

   assign z38   = {{6{angle_ff[31]}}, angle_ff} <<< 6;
   assign z_abs = z38[37] ? 38'(-z38) : 38'(z38);
   assign mod_step = TWO_PI_MAG << k_ff;

   // one cordic micro-rotation
   always_comb begin
      xs = x_ff >>> i_ff;
      ys = y_ff >>> i_ff;
      if (!z_ff[35]) begin
         x_in = x_ff - ys;
         y_in = y_ff + xs;
      end else begin
         x_in = x_ff + ys;
         y_in = y_ff - xs;
      end
   end

   assign add_na   = 49'(angle_ff) + 49'(mul_rsp.value);
   assign add_t2   = 49'(t1_ff) + 49'(mul_rsp.value);
   assign add_nv   = 49'(speed_ff) - 49'(mul_rsp.value);
   assign add_nx   = 49'(dist_ff) + 49'(mul_rsp.value);
   assign add_nh   = 49'(height_ff) + 49'(mul_rsp.value);
   assign add_rate = 49'(klv_ff) - 49'(q_ff);
   assign cl_na    = clamp32(add_na);
   assign cl_t2    = clamp48(add_t2);
   assign cl_nv    = clamp48(add_nv);
   assign cl_nx    = clamp48(add_nx);
   assign cl_nh    = clamp48(add_nh);
   assign cl_rate  = clamp48(add_rate);
   assign dt_rnd   = (33'(dt_ff) + 33'd128) >> 8;
   assign nt_sum   = 49'(time_ff) + 49'(dt_rnd);

   // operand selection for the shared multiplier
   always_comb begin
      mul_req.start = (state_ff == S_MUL_GO);
      case (op_ff)
         OP_KLV: begin
            mul_req.a = 48'(lift_ff); mul_req.b = speed_ff; mul_req.sh = SH16;
         end
         OP_GC: begin
            mul_req.a = 48'(grav_ff); mul_req.b = 48'(c_ff); mul_req.sh = SH30;
         end
         OP_V2: begin
            mul_req.a = speed_ff; mul_req.b = speed_ff; mul_req.sh = SH16;
         end
         OP_T1: begin
            mul_req.a = 48'(drag_ff); mul_req.b = v2_ff; mul_req.sh = SH24;
         end
         OP_T2: begin
            mul_req.a = 48'(grav_ff); mul_req.b = 48'(s_ff); mul_req.sh = SH38;
         end
         OP_VC: begin
            mul_req.a = speed_ff; mul_req.b = 48'(c_ff); mul_req.sh = SH30;
         end
         OP_VS: begin
            mul_req.a = speed_ff; mul_req.b = 48'(s_ff); mul_req.sh = SH30;
         end
         default: begin
            // dt times the rate or derivative term held in term_ff
            mul_req.a = 48'(dt_ff); mul_req.b = term_ff; mul_req.sh = SH24;
         end
      endcase
   end

   assign div_req.start    = (state_ff == S_DIV) && (speed_ff != '0);
   assign div_req.dividend = {gc_ff, 16'h0000};
   assign div_req.divisor  = speed_ff;

   gtes_mul u_mul (
      .clock   (clock),
      .reset   (reset),
      .mul_req (mul_req),
      .mul_rsp (mul_rsp)
   );

   gtes_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         lift_ff <= '0;
         drag_ff <= '0;
         grav_ff <= 32'd164577526;
         dt_ff   <= 32'd167772;
         end_ff  <= 48'd6553600;
      end else if (csr_we) begin
         case (csr_index)
            REG_LIFT: lift_ff <= csr_wdata[31:0];
            REG_DRAG: drag_ff <= csr_wdata[31:0];
            REG_GRAV: grav_ff <= csr_wdata[31:0];
            REG_DT:   dt_ff   <= csr_wdata[31:0];
            REG_END:  end_ff  <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         op_ff         <= OP_KLV;
         time_ff       <= '0;
         speed_ff      <= '0;
         angle_ff      <= '0;
         dist_ff       <= '0;
         height_ff     <= '0;
         run_over_ff   <= 1'b1;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         if (rsp_load) rsp_tvalid_ff <= 1'b1;
         else if (rsp_tvalid_ff && rsp_tready) rsp_tvalid_ff <= 1'b0;
         case (state_ff)
            S_IDLE: begin
               if (req_beat) begin
                  sat_ff <= 1'b0;
                  if (req_tuser[0] == CMD_RESTART) begin
                     speed_ff      <= in_speed;
                     angle_ff      <= in_angle;
                     dist_ff       <= in_dist;
                     height_ff     <= in_height;
                     time_ff       <= '0;
                     run_over_ff   <= 1'b0;
                     rec_time_ff   <= '0;
                     rec_speed_ff  <= in_speed;
                     rec_angle_ff  <= in_angle;
                     rec_dist_ff   <= in_dist;
                     rec_height_ff <= in_height;
                     fin_rec_ff    <= 1'b0;
                     state_ff      <= S_OUT;
                  end else begin
                     rec_time_ff   <= time_ff;
                     rec_speed_ff  <= speed_ff;
                     rec_angle_ff  <= angle_ff;
                     rec_dist_ff   <= dist_ff;
                     rec_height_ff <= height_ff;
                     if (run_over_ff || (time_ff > end_ff) || height_ff[47]) begin
                        run_over_ff <= 1'b1;
                        fin_rec_ff  <= 1'b1;
                        state_ff    <= S_OUT;
                     end else begin
                        fin_rec_ff <= 1'b0;
                        zmag_ff    <= z_abs;
                        zneg_ff    <= z38[37];
                        k_ff       <= 3'd4;
                        state_ff   <= S_MOD;
                     end
                  end
               end
            end
            // remainder by two pi, one binary digit a cycle
            S_MOD: begin
               if (zmag_ff >= mod_step) zmag_ff <= zmag_ff - mod_step;
               if (k_ff == 3'd0) state_ff <= S_SIGN;
               else k_ff <= k_ff - 3'd1;
            end
            S_SIGN: begin
               z_ff     <= zneg_ff ? 36'(-zmag_ff) : 36'(zmag_ff);
               state_ff <= S_WRAP;
            end
            S_WRAP: begin
               if (z_ff > Q30_PI) z_ff <= z_ff - Q30_TWO_PI;
               else if (z_ff < -Q30_PI) z_ff <= z_ff + Q30_TWO_PI;
               state_ff <= S_HALF;
            end
            // fold into the right half plane, sign fixed after rotation
            S_HALF: begin
               if (z_ff > Q30_HALF_PI) begin
                  z_ff    <= z_ff - Q30_PI;
                  flip_ff <= 1'b1;
               end else if (z_ff < -Q30_HALF_PI) begin
                  z_ff    <= z_ff + Q30_PI;
                  flip_ff <= 1'b1;
               end else begin
                  flip_ff <= 1'b0;
               end
               x_ff     <= Q30_GAIN;
               y_ff     <= '0;
               i_ff     <= '0;
               state_ff <= S_ROT;
            end
            S_ROT: begin
               x_ff <= x_in;
               y_ff <= y_in;
               z_ff <= z_ff[35] ? z_ff + atan_q30(i_ff) : z_ff - atan_q30(i_ff);
               i_ff <= i_ff + 5'd1;
               if (i_ff == LAST_ROT) begin
                  c_ff     <= flip_ff ? -x_in : x_in;
                  s_ff     <= flip_ff ? -y_in : y_in;
                  op_ff    <= OP_KLV;
                  state_ff <= S_MUL_GO;
               end
            end
            S_MUL_GO: state_ff <= S_MUL_WAIT;
            S_MUL_WAIT: begin
               if (mul_rsp.done) begin
                  case (op_ff)
                     OP_KLV: begin
                        klv_ff   <= mul_rsp.value;
                        sat_ff   <= sat_ff | mul_rsp.sat;
                        op_ff    <= OP_GC;
                        state_ff <= S_MUL_GO;
                     end
                     OP_GC: begin
                        gc_ff    <= mul_rsp.value;
                        sat_ff   <= sat_ff | mul_rsp.sat;
                        state_ff <= S_DIV;
                     end
                     OP_NA: begin
                        na_ff    <= cl_na[31:0];
                        sat_ff   <= sat_ff | mul_rsp.sat | cl_na[32];
                        op_ff    <= OP_V2;
                        state_ff <= S_MUL_GO;
                     end
                     OP_V2: begin
                        v2_ff    <= mul_rsp.value;
                        sat_ff   <= sat_ff | mul_rsp.sat;
                        op_ff    <= OP_T1;
                        state_ff <= S_MUL_GO;
                     end
                     OP_T1: begin
                        t1_ff    <= mul_rsp.value;
                        sat_ff   <= sat_ff | mul_rsp.sat;
                        op_ff    <= OP_T2;
                        state_ff <= S_MUL_GO;
                     end
                     OP_T2: begin
                        term_ff  <= cl_t2[47:0];
                        sat_ff   <= sat_ff | mul_rsp.sat | cl_t2[48];
                        op_ff    <= OP_NV;
                        state_ff <= S_MUL_GO;
                     end
                     OP_NV: begin
                        nv_ff    <= cl_nv[47:0];
                        sat_ff   <= sat_ff | mul_rsp.sat | cl_nv[48];
                        op_ff    <= OP_VC;
                        state_ff <= S_MUL_GO;
                     end
                     OP_VC: begin
                        term_ff  <= mul_rsp.value;
                        sat_ff   <= sat_ff | mul_rsp.sat;
                        op_ff    <= OP_NX;
                        state_ff <= S_MUL_GO;
                     end
                     OP_NX: begin
                        nx_ff    <= cl_nx[47:0];
                        sat_ff   <= sat_ff | mul_rsp.sat | cl_nx[48];
                        op_ff    <= OP_VS;
                        state_ff <= S_MUL_GO;
                     end
                     OP_VS: begin
                        term_ff  <= mul_rsp.value;
                        sat_ff   <= sat_ff | mul_rsp.sat;
                        op_ff    <= OP_NH;
                        state_ff <= S_MUL_GO;
                     end
                     default: begin
                        nh_ff    <= cl_nh[47:0];
                        sat_ff   <= sat_ff | mul_rsp.sat | cl_nh[48];
                        state_ff <= S_COMMIT;
                     end
                  endcase
               end
            end
            // zero speed: full scale with the sign of the numerator
            S_DIV: begin
               if (speed_ff == '0) begin
                  sat_ff <= 1'b1;
                  if (gc_ff == '0) q_ff <= '0;
                  else q_ff <= gc_ff[47] ? MIN48 : MAX48;
                  state_ff <= S_RATE;
               end else begin
                  state_ff <= S_DIV_WAIT;
               end
            end
            S_DIV_WAIT: begin
               if (div_rsp.done) begin
                  q_ff     <= div_rsp.value;
                  sat_ff   <= sat_ff | div_rsp.sat;
                  state_ff <= S_RATE;
               end
            end
            S_RATE: begin
               term_ff  <= cl_rate[47:0];
               sat_ff   <= sat_ff | cl_rate[48];
               op_ff    <= OP_NA;
               state_ff <= S_MUL_GO;
            end
            S_COMMIT: begin
               angle_ff  <= na_ff;
               speed_ff  <= nv_ff;
               dist_ff   <= nx_ff;
               height_ff <= nh_ff;
               if (nt_sum[48]) begin
                  time_ff <= {48{1'b1}};
                  sat_ff  <= 1'b1;
               end else begin
                  time_ff <= nt_sum[47:0];
               end
               state_ff <= S_OUT;
            end
            S_OUT: begin
               if (rsp_load) begin
                  rsp_tdata_ff  <= {rec_height_ff, rec_dist_ff, rec_angle_ff,
                                    rec_speed_ff, rec_time_ff};
                  rsp_tuser_ff  <= {sat_ff, fin_rec_ff};
                  state_ff      <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;
   assign rsp_tuser  = rsp_tuser_ff;

   `GTES_ASSERT(a_step_after_end_finishes, clock, reset, (req_beat && req_tuser[0] == CMD_STEP && run_over_ff) |=> (fin_rec_ff && state_ff == S_OUT))
   `GTES_ASSERT(a_div_nonzero_speed, clock, reset, div_req.start |-> (speed_ff != '0 && state_ff == S_DIV))
   `GTES_ASSERT(a_mul_start_from_seq, clock, reset, mul_rsp.done |-> (state_ff == S_MUL_WAIT))
   `GTES_ASSERT_RST(a_reset_clears, clock, reset |=> (state_ff == S_IDLE && run_over_ff && !rsp_tvalid_ff))

endmodule

// File: tb/sv/glider_trajectory_euler_step_tb.sv
// ----------------------------------------------------------------------------
// glider_trajectory_euler_step_tb
// directed table plus random flight runs over several register settings.
// every result beat is checked against an euler-step flight predictor or a literal table entry.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module glider_trajectory_euler_step_tb;
   import gtes_pkg::*;

   typedef struct {
      logic [47:0]        tm;
      logic signed [47:0] spd;
      logic signed [31:0] ang;
      logic signed [47:0] dst;
      logic signed [47:0] hgt;
      logic               fin;
      logic               sat;
   } flight_rec_type;

   typedef struct {
      cmd_type            cmd;
      logic signed [47:0] spd;
      logic signed [31:0] ang;
      logic signed [47:0] dst;
      logic signed [47:0] hgt;
      bit                 lit;
      flight_rec_type     want;
   } dir_row_type;

   localparam logic [2:0] REG_LIFT = 3'd0;
   localparam logic [2:0] REG_DRAG = 3'd1;
   localparam logic [2:0] REG_GRAV = 3'd2;
   localparam logic [2:0] REG_STEP = 3'd3;
   localparam logic [2:0] REG_END  = 3'd4;

   localparam longint TWO_PI_Q30  = 64'sd6746518852;
   localparam longint PI_Q30      = 64'sd3373259426;
   localparam longint HALF_PI_Q30 = 64'sd1686629713;
   localparam longint GAIN_Q30    = 64'sd652032874;
   localparam longint ATAN_TAB [32] = '{
      843314857, 497837830, 263043837, 133525159, 67021687, 33543516,
      16775851, 8388437, 4194283, 2097149, 1048576, 524288, 262144,
      131072, 65536, 32768, 16384, 8192, 4096, 2048, 1024, 512, 256,
      128, 64, 32, 16, 8, 4, 2, 1, 0};
   localparam longint S48_MAX = 64'sh7FFF_FFFF_FFFF;
   localparam longint S48_MIN = -64'sh8000_0000_0000;

   logic         clock;
   logic         reset;
   logic         req_tvalid;
   logic         req_tready;
   logic [175:0] req_tdata;
   logic [0:0]   req_tuser;
   logic         rsp_tvalid;
   logic         rsp_tready;
   logic [223:0] rsp_tdata;
   logic [1:0]   rsp_tuser;
   logic         csr_we;
   logic [2:0]   csr_index;
   logic [47:0]  csr_wdata;

   glider_trajectory_euler_step uut (.*);

   // predictor copy of registers and flight state
   longint lift_k, drag_k, grav_k, dt_k, end_k;
   longint t_now, spd_now, ang_now, dst_now, hgt_now;
   bit     run_done;

   flight_rec_type rec_q [$];
   int             errors;
   int             burst_left;
   int             rcv_cnt;
   int             rcv_mode;

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   initial begin
      #50ms;
      $display("FAIL");
      $finish;
   end

   function automatic longint mul_round(longint a, longint b, int sh, inout bit sat);
      logic [127:0] p;
      logic [63:0]  ma, mb, lim;
      bit           neg;
      neg = (a < 0) != (b < 0);
      ma  = (a < 0) ? 64'(0) - 64'(a) : 64'(a);
      mb  = (b < 0) ? 64'(0) - 64'(b) : 64'(b);
      p   = {64'b0, ma} * {64'b0, mb};
      p   = (p + (128'd1 << (sh - 1))) >> sh;
      lim = neg ? 64'h8000_0000_0000 : 64'h7FFF_FFFF_FFFF;
      if (p > {64'b0, lim}) begin
         sat = 1'b1;
         p   = {64'b0, lim};
      end
      return neg ? -longint'(p[63:0]) : longint'(p[63:0]);
   endfunction

   function automatic longint clip(longint v, int w, inout bit sat);
      longint hi, lo;
      hi = (64'sd1 <<< (w - 1)) - 1;
      lo = -hi - 1;
      if (v > hi) begin
         sat = 1'b1;
         return hi;
      end
      if (v < lo) begin
         sat = 1'b1;
         return lo;
      end
      return v;
   endfunction

   function automatic void sin_cos(longint ang24, output longint c, output longint s);
      longint z, x, y, xs, ys;
      bit     flip;
      z    = (ang24 * 64) % TWO_PI_Q30;
      x    = GAIN_Q30;
      y    = 0;
      flip = 1'b0;
      if (z > PI_Q30) z -= TWO_PI_Q30;
      else if (z < -PI_Q30) z += TWO_PI_Q30;
      // fold into the right half plane, negate at the end
      if (z > HALF_PI_Q30) begin
         z -= PI_Q30;
         flip = 1'b1;
      end else if (z < -HALF_PI_Q30) begin
         z += PI_Q30;
         flip = 1'b1;
      end
      for (int i = 0; i < CORDIC_STEPS && i < 32; i++) begin
         xs = x >>> i;
         ys = y >>> i;
         if (z >= 0) begin
            x -= ys;
            y += xs;
            z -= ATAN_TAB[i];
         end else begin
            x += ys;
            y -= xs;
            z += ATAN_TAB[i];
         end
      end
      c = flip ? -x : x;
      s = flip ? -y : y;
   endfunction

   function automatic flight_rec_type advance_glider(cmd_type cmd, logic signed [47:0] s0,
         logic signed [31:0] a0, logic signed [47:0] d0, logic signed [47:0] h0);
      flight_rec_type r;
      bit     sat, fin;
      longint c, s, klv, gc, q, rate, v2, acc, vc, vs, na, nv, nx, nh, nt;
      sat = 1'b0;
      fin = 1'b0;
      if (cmd == CMD_RESTART) begin
         spd_now  = s0;
         ang_now  = a0;
         dst_now  = d0;
         hgt_now  = h0;
         t_now    = 0;
         run_done = 1'b0;
      end
      r.tm  = t_now[47:0];
      r.spd = spd_now[47:0];
      r.ang = ang_now[31:0];
      r.dst = dst_now[47:0];
      r.hgt = hgt_now[47:0];
      if (cmd == CMD_STEP) begin
         if (run_done || t_now > end_k || hgt_now < 0) begin
            run_done = 1'b1;
            fin      = 1'b1;
         end else begin
            sin_cos(ang_now, c, s);
            klv = mul_round(lift_k, spd_now, 16, sat);
            gc  = mul_round(grav_k, c, 30, sat);
            // zero speed: full scale with the sign of the numerator
            if (spd_now == 0) begin
               sat = 1'b1;
               q   = gc > 0 ? S48_MAX : (gc < 0 ? S48_MIN : 0);
            end else begin
               q = clip((gc * 65536) / spd_now, 48, sat);
            end
            rate = clip(klv - q, 48, sat);
            na   = clip(ang_now + mul_round(dt_k, rate, 24, sat), 32, sat);
            v2   = mul_round(spd_now, spd_now, 16, sat);
            acc  = clip(mul_round(drag_k, v2, 24, sat) + mul_round(grav_k, s, 38, sat),
                        48, sat);
            nv   = clip(spd_now - mul_round(dt_k, acc, 24, sat), 48, sat);
            vc   = mul_round(spd_now, c, 30, sat);
            vs   = mul_round(spd_now, s, 30, sat);
            nx   = clip(dst_now + mul_round(dt_k, vc, 24, sat), 48, sat);
            nh   = clip(hgt_now + mul_round(dt_k, vs, 24, sat), 48, sat);
            nt   = t_now + ((dt_k + 128) >>> 8);
            if (nt > 64'sh0000_FFFF_FFFF_FFFF) begin
               nt  = 64'sh0000_FFFF_FFFF_FFFF;
               sat = 1'b1;
            end
            ang_now = na;
            spd_now = nv;
            dst_now = nx;
            hgt_now = nh;
            t_now   = nt;
         end
      end
      r.fin = fin;
      r.sat = sat;
      return r;
   endfunction

   task automatic report(string what, longint got, longint want);
      $display("mismatch %s: got %h want %h", what, got, want);
      errors++;
   endtask

   // one request beat; valid stays high across a burst
   task automatic send_beat(cmd_type cmd, logic signed [47:0] s0, logic signed [31:0] a0,
         logic signed [47:0] d0, logic signed [47:0] h0, bit lit, flight_rec_type want);
      flight_rec_type r;
      req_tvalid <= 1'b1;
      req_tuser  <= cmd;
      req_tdata  <= {h0, d0, a0, s0};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      r = advance_glider(cmd, s0, a0, d0, h0);
      rec_q.push_back(lit ? want : r);
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 25)) @(posedge clock);
         burst_left = $urandom_range(0, 10);
      end
   endtask

   task automatic write_regs(longint lf, longint df, longint gv, longint ts, longint et);
      longint vals [5];
      vals = '{lf, df, gv, ts, et};
      req_tvalid <= 1'b0;
      while (rec_q.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      for (int i = 0; i < 5; i++) begin
         csr_we    <= 1'b1;
         csr_index <= 3'(i);
         csr_wdata <= vals[i][47:0];
         @(posedge clock);
      end
      csr_we <= 1'b0;
      lift_k = lf & 64'hFFFF_FFFF;
      drag_k = df & 64'hFFFF_FFFF;
      grav_k = gv & 64'hFFFF_FFFF;
      dt_k   = ts & 64'hFFFF_FFFF;
      end_k  = et & 64'hFFFF_FFFF_FFFF;
   endtask

   function automatic logic [47:0] rnd48();
      return {$urandom, $urandom};
   endfunction

   task automatic random_phase(int n_items);
      flight_rec_type none;
      int             done_items, steps;
      none = '{default: '0};
      done_items = 0;
      while (done_items < n_items) begin
         if ($urandom_range(0, 9) < 8) begin
            // sane launch then a run of steps
            send_beat(CMD_RESTART, 48'($urandom_range(1, 120)) <<< 16 | 48'($urandom_range(0, 65535)),
                      $signed(32'($urandom_range(0, 20000000))) - 32'sd10000000,
                      $signed(rnd48()) >>> 8, 48'($urandom_range(0, 3000)) <<< 16, 1'b0, none);
            steps = $urandom_range(1, 30);
            for (int i = 0; i < steps; i++)
               send_beat(CMD_STEP, rnd48(), $urandom, rnd48(), rnd48(), 1'b0, none);
            done_items += steps + 1;
         end else begin
            send_beat(cmd_type'($urandom_range(0, 1)), rnd48(), $urandom, rnd48(), rnd48(),
                      1'b0, none);
            done_items++;
         end
      end
   endtask

   // receiver stalls in modes that change whenever the low byte of rcv_cnt is zero
   always @(posedge clock) begin
      rcv_cnt <= rcv_cnt + 1;
      if (rcv_cnt[7:0] == 8'd0) rcv_mode <= $urandom_range(0, 2);
      case (rcv_mode)
         0: begin
            rsp_tready <= 1'b1;
         end
         1: begin
            rsp_tready <= ($urandom_range(0, 3) != 0);
         end
         default: begin
            rsp_tready <= rcv_cnt[4];
         end
      endcase
   end

   always @(posedge clock) begin
      flight_rec_type w;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (rec_q.size() == 0) begin
            $display("unexpected result beat");
            errors++;
         end else begin
            w = rec_q.pop_front();
            if (rsp_tdata[47:0] !== w.tm) report("sim_time", rsp_tdata[47:0], w.tm);
            if (rsp_tdata[95:48] !== w.spd) report("speed", rsp_tdata[95:48], w.spd);
            if (rsp_tdata[127:96] !== w.ang) report("path_angle", rsp_tdata[127:96], w.ang);
            if (rsp_tdata[175:128] !== w.dst) report("distance", rsp_tdata[175:128], w.dst);
            if (rsp_tdata[223:176] !== w.hgt) report("height", rsp_tdata[223:176], w.hgt);
            if (rsp_tuser[0] !== w.fin) report("finished", rsp_tuser[0], w.fin);
            if (rsp_tuser[1] !== w.sat) report("saturated", rsp_tuser[1], w.sat);
         end
      end
   end

   initial begin
      dir_row_type    rows [$];
      flight_rec_type none;
      int             wait_cnt;
      none       = '{default: '0};
      errors     = 0;
      burst_left = 0;
      rcv_cnt    = 0;
      rcv_mode   = 0;
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tuser  = '0;
      rsp_tready = 1'b0;
      csr_we     = 1'b0;
      csr_index  = REG_LIFT;
      csr_wdata  = '0;
      lift_k = 0; drag_k = 0; grav_k = 164577526; dt_k = 167772; end_k = 6553600;
      t_now = 0; spd_now = 0; ang_now = 0; dst_now = 0; hgt_now = 0;
      run_done = 1'b1;

      // step before any launch, full-scale launches, zero speed, angle wrap
      rows.push_back('{CMD_STEP, 0, 0, 0, 0, 1, '{0, 0, 0, 0, 0, 1, 0}});
      rows.push_back('{CMD_RESTART, S48_MAX, 32'h7FFF_FFFF, S48_MAX, S48_MAX, 1,
                       '{0, S48_MAX, 32'h7FFF_FFFF, S48_MAX, S48_MAX, 0, 0}});
      rows.push_back('{CMD_STEP, 0, 0, 0, 0, 0, none});
      rows.push_back('{CMD_STEP, 0, 0, 0, 0, 0, none});
      rows.push_back('{CMD_RESTART, S48_MIN, 32'h8000_0000, S48_MIN, S48_MIN, 1,
                       '{0, S48_MIN, 32'h8000_0000, S48_MIN, S48_MIN, 0, 0}});
      rows.push_back('{CMD_STEP, -1, -1, -1, -1, 1,
                       '{0, S48_MIN, 32'h8000_0000, S48_MIN, S48_MIN, 1, 0}});
      rows.push_back('{CMD_STEP, 0, 0, 0, 0, 1,
                       '{0, S48_MIN, 32'h8000_0000, S48_MIN, S48_MIN, 1, 0}});
      rows.push_back('{CMD_RESTART, 0, 0, 0, 1000 <<< 16, 1,
                       '{0, 0, 0, 0, 1000 <<< 16, 0, 0}});
      rows.push_back('{CMD_STEP, 0, 0, 0, 0, 0, none});
      rows.push_back('{CMD_STEP, 0, 0, 0, 0, 0, none});
      rows.push_back('{CMD_RESTART, 30 <<< 16, 52707179, 0, 500 <<< 16, 0, none});
      rows.push_back('{CMD_STEP, 0, 0, 0, 0, 0, none});
      rows.push_back('{CMD_STEP, 0, 0, 0, 0, 0, none});
      rows.push_back('{CMD_RESTART, -(20 <<< 16), -26353589, 5, 100 <<< 16, 0, none});
      rows.push_back('{CMD_STEP, 0, 0, 0, 0, 0, none});
      rows.push_back('{CMD_RESTART, 1, 32'h7FFF_FFFF, -7, 0, 0, none});
      rows.push_back('{CMD_STEP, 0, 0, 0, 0, 0, none});
      rows.push_back('{CMD_STEP, 0, 0, 0, 0, 0, none});

      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (rows[i])
         send_beat(rows[i].cmd, rows[i].spd, rows[i].ang, rows[i].dst, rows[i].hgt,
                   rows[i].lit, rows[i].want);
      random_phase(120);

      write_regs(838861, 33554, 164577526, 167772, 100 <<< 16);
      random_phase(300);
      write_regs(0, 0, 0, 1, 0);
      random_phase(120);
      write_regs(64'hFFFF_FFFF, 64'hFFFF_FFFF, 64'hFFFF_FFFF, 64'hFFFF_FFFF,
                 64'hFFFF_FFFF_FFFF);
      random_phase(120);
      write_regs(838861, 33554, 164577526, 167772, 0);
      random_phase(120);
      write_regs(3000000, 500000, 164577526, 32'h1000_0000, 1000 <<< 16);
      random_phase(200);

      req_tvalid <= 1'b0;
      wait_cnt = 0;
      while (rec_q.size() != 0 && wait_cnt < 200000) begin
         @(posedge clock);
         wait_cnt++;
      end
      repeat (300) @(posedge clock);
      if (rec_q.size() != 0) begin
         $display("%0d results never arrived", rec_q.size());
         errors++;
      end
      if (errors == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
